// ===== rtl/core/one_shot_and_repeat_timer_table_top_assert.svh =====
`ifndef ONE_SHOT_AND_REPEAT_TIMER_TABLE_TOP_ASSERT_SVH
`define ONE_SHOT_AND_REPEAT_TIMER_TABLE_TOP_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define OSTT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OSTT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ostt_pkg.sv =====
`default_nettype none

package ostt_pkg;

    localparam int NOW_W = 48;
    localparam int PER_W = 32;
    localparam int ID_W  = 31;

    localparam logic [1:0] OP_SCHED  = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    typedef enum logic [1:0] {
        KIND_ASSIGNED = 2'd0,
        KIND_FULL     = 2'd1,
        KIND_FIRED    = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCHED,
        ST_CANCEL,
        ST_TICK_INC,
        ST_TICK,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [NOW_W-1:0] target;
        logic [PER_W-1:0] period;
        logic             rpt;
        logic [ID_W-1:0]  id;
    } t_slot;

    typedef struct packed {
        logic            vld;
        t_kind           kind;
        logic [ID_W-1:0] id;
        logic            last;
    } t_push;

endpackage

`default_nettype wire

// ===== rtl/core/ostt_alu.sv =====
`default_nettype none

module ostt_alu (
    input  wire logic [ostt_pkg::NOW_W-1:0] i_add_a,
    input  wire logic [ostt_pkg::PER_W-1:0] i_add_b,
    output logic      [ostt_pkg::NOW_W-1:0] o_sum,
    input  wire logic [ostt_pkg::NOW_W-1:0] i_le_a,
    input  wire logic [ostt_pkg::NOW_W-1:0] i_le_b,
    output logic                            o_le,
    input  wire logic [ostt_pkg::ID_W-1:0]  i_eq_a,
    input  wire logic [ostt_pkg::ID_W-1:0]  i_eq_b,
    output logic                            o_eq
);

    assign o_sum = i_add_a + {{(ostt_pkg::NOW_W - ostt_pkg::PER_W){1'b0}}, i_add_b};
    assign o_le  = (i_le_a <= i_le_b);
    assign o_eq  = (i_eq_a == i_eq_b);

endmodule

`default_nettype wire

// ===== rtl/core/ostt_mem.sv =====
`default_nettype none

module ostt_mem #(
    parameter  int SLOTS = 16,
    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [IW-1:0]   i_waddr,
    input  wire ostt_pkg::t_slot i_wdata,
    input  wire logic            i_re,
    input  wire logic [IW-1:0]   i_raddr,
    output ostt_pkg::t_slot      o_rdata
);

    ostt_pkg::t_slot r_mem [SLOTS];
    ostt_pkg::t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/ostt_seq.sv =====
`default_nettype none

module ostt_seq #(
    parameter  int SLOTS = 16,
    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [1:0]                      i_opcode,
    input  wire logic [ostt_pkg::PER_W-1:0]      i_interval,
    input  wire logic                            i_repeat,
    input  wire logic [ostt_pkg::ID_W-1:0]       i_cid,
    input  wire logic                            i_out_free,
    output logic                                 o_idle,
    output ostt_pkg::t_push                      o_push
);

    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    ostt_pkg::t_state r_state, n_state;

    logic [IW-1:0]              r_idx, n_idx;
    logic                       r_issuing, n_issuing;
    logic                       r_ev_vld, n_ev_vld;
    logic [IW-1:0]              r_ev_idx, n_ev_idx;
    logic [SLOTS-1:0]           r_valid, n_valid;
    logic [ostt_pkg::NOW_W-1:0] r_now, n_now;
    logic [ostt_pkg::ID_W-1:0]  r_next_id, n_next_id;
    logic                       r_pend_vld, n_pend_vld;
    logic [ostt_pkg::ID_W-1:0]  r_pend_id, n_pend_id;
    logic [ostt_pkg::PER_W-1:0] r_interval, n_interval;
    logic                       r_repeat, n_repeat;
    logic [ostt_pkg::ID_W-1:0]  r_cid, n_cid;

    ostt_pkg::t_slot            w_rd;
    ostt_pkg::t_slot            w_wdata;
    logic                       w_we;
    logic [IW-1:0]              w_waddr;
    logic                       w_re;
    logic [ostt_pkg::PER_W-1:0] w_add_b;
    logic [ostt_pkg::NOW_W-1:0] w_sum;
    logic                       w_le;
    logic                       w_eq;
    logic [ostt_pkg::ID_W-1:0]  w_id_inc;
    logic                       w_sched_free;
    logic                       w_walk_done;
    logic                       w_ev_valid;
    logic                       w_fire;
    logic                       w_hit;
    logic                       w_adv;

    ostt_mem #(.SLOTS(SLOTS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_idx),
        .o_rdata (w_rd)
    );

    ostt_alu u_alu (
        .i_add_a (r_now),
        .i_add_b (w_add_b),
        .o_sum   (w_sum),
        .i_le_a  (w_rd.target),
        .i_le_b  (r_now),
        .o_le    (w_le),
        .i_eq_a  (w_rd.id),
        .i_eq_b  (r_cid),
        .o_eq    (w_eq)
    );

    assign w_id_inc     = r_next_id + ostt_pkg::ID_W'(1);
    assign w_sched_free = !r_valid[r_idx];
    assign w_walk_done  = !r_issuing && !r_ev_vld;
    assign w_ev_valid   = r_valid[r_ev_idx];
    assign w_fire       = (r_state == ostt_pkg::ST_TICK) && r_ev_vld && w_ev_valid && w_le;
    assign w_hit        = (r_state == ostt_pkg::ST_CANCEL) && r_ev_vld && w_ev_valid && w_eq;
    // a second firing waits while the held one cannot leave
    assign w_adv        = !(w_fire && r_pend_vld && !i_out_free);
    assign o_idle       = (r_state == ostt_pkg::ST_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ostt_pkg::ST_IDLE: begin
                if (i_start) begin
                    case (i_opcode)
                        ostt_pkg::OP_SCHED:  n_state = ostt_pkg::ST_SCHED;
                        ostt_pkg::OP_CANCEL: n_state = ostt_pkg::ST_CANCEL;
                        ostt_pkg::OP_TICK:   n_state = ostt_pkg::ST_TICK_INC;
                        default:             n_state = ostt_pkg::ST_IDLE;
                    endcase
                end
            end
            ostt_pkg::ST_SCHED: begin
                if (i_out_free && (w_sched_free || r_idx == LAST_IDX)) begin
                    n_state = ostt_pkg::ST_IDLE;
                end
            end
            ostt_pkg::ST_CANCEL: begin
                if (w_walk_done) begin
                    n_state = ostt_pkg::ST_IDLE;
                end
            end
            ostt_pkg::ST_TICK_INC: begin
                n_state = ostt_pkg::ST_TICK;
            end
            ostt_pkg::ST_TICK: begin
                if (w_walk_done) begin
                    n_state = ostt_pkg::ST_FLUSH;
                end
            end
            ostt_pkg::ST_FLUSH: begin
                if (!r_pend_vld || i_out_free) begin
                    n_state = ostt_pkg::ST_IDLE;
                end
            end
            default: n_state = ostt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_push  = '0;
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = w_rd;
        w_re    = 1'b0;
        w_add_b = w_rd.period;
        case (r_state)
            ostt_pkg::ST_SCHED: begin
                w_add_b = r_interval;
                if (i_out_free && w_sched_free) begin
                    o_push.vld     = 1'b1;
                    o_push.kind    = ostt_pkg::KIND_ASSIGNED;
                    o_push.id      = w_id_inc;
                    o_push.last    = 1'b1;
                    w_we           = 1'b1;
                    w_wdata.target = w_sum;
                    w_wdata.period = r_interval;
                    w_wdata.rpt    = r_repeat;
                    w_wdata.id     = w_id_inc;
                end else if (i_out_free && r_idx == LAST_IDX) begin
                    o_push.vld  = 1'b1;
                    o_push.kind = ostt_pkg::KIND_FULL;
                    o_push.last = 1'b1;
                end
            end
            ostt_pkg::ST_CANCEL: begin
                w_re = r_issuing;
            end
            ostt_pkg::ST_TICK_INC: begin
                w_add_b = ostt_pkg::PER_W'(1);
            end
            ostt_pkg::ST_TICK: begin
                w_re = r_issuing && w_adv;
                if (w_fire && w_adv) begin
                    if (r_pend_vld) begin
                        o_push.vld  = 1'b1;
                        o_push.kind = ostt_pkg::KIND_FIRED;
                        o_push.id   = r_pend_id;
                    end
                    w_we           = w_rd.rpt;
                    w_waddr        = r_ev_idx;
                    w_wdata.target = w_sum;
                end
            end
            ostt_pkg::ST_FLUSH: begin
                if (r_pend_vld && i_out_free) begin
                    o_push.vld  = 1'b1;
                    o_push.kind = ostt_pkg::KIND_FIRED;
                    o_push.id   = r_pend_id;
                    o_push.last = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_idx      = r_idx;
        n_issuing  = r_issuing;
        n_ev_vld   = r_ev_vld;
        n_ev_idx   = r_ev_idx;
        n_valid    = r_valid;
        n_now      = r_now;
        n_next_id  = r_next_id;
        n_pend_vld = r_pend_vld;
        n_pend_id  = r_pend_id;
        n_interval = r_interval;
        n_repeat   = r_repeat;
        n_cid      = r_cid;
        case (r_state)
            ostt_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_interval = i_interval;
                    n_repeat   = i_repeat;
                    n_cid      = i_cid;
                    n_idx      = '0;
                    n_issuing  = 1'b1;
                    n_ev_vld   = 1'b0;
                    n_pend_vld = 1'b0;
                end
            end
            ostt_pkg::ST_SCHED: begin
                if (w_sched_free) begin
                    if (i_out_free) begin
                        n_valid[r_idx] = 1'b1;
                        n_next_id      = w_id_inc;
                    end
                end else if (r_idx != LAST_IDX) begin
                    n_idx = r_idx + IW'(1);
                end
            end
            ostt_pkg::ST_TICK_INC: begin
                n_now = w_sum;
            end
            ostt_pkg::ST_CANCEL, ostt_pkg::ST_TICK: begin
                if (w_adv) begin
                    n_ev_vld = r_issuing;
                    n_ev_idx = r_idx;
                    if (r_issuing) begin
                        if (r_idx == LAST_IDX) begin
                            n_issuing = 1'b0;
                        end else begin
                            n_idx = r_idx + IW'(1);
                        end
                    end
                end
                if (w_hit) begin
                    n_valid[r_ev_idx] = 1'b0;
                end
                if (w_fire && w_adv) begin
                    n_pend_vld = 1'b1;
                    n_pend_id  = w_rd.id;
                    if (!w_rd.rpt) begin
                        n_valid[r_ev_idx] = 1'b0;
                    end
                end
            end
            ostt_pkg::ST_FLUSH: begin
                if (i_out_free) begin
                    n_pend_vld = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ostt_pkg::ST_IDLE;
            r_idx      <= '0;
            r_issuing  <= 1'b0;
            r_ev_vld   <= 1'b0;
            r_valid    <= '0;
            r_now      <= '0;
            r_next_id  <= '0;
            r_pend_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_issuing  <= n_issuing;
            r_ev_vld   <= n_ev_vld;
            r_valid    <= n_valid;
            r_now      <= n_now;
            r_next_id  <= n_next_id;
            r_pend_vld <= n_pend_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev_idx   <= n_ev_idx;
        r_pend_id  <= n_pend_id;
        r_interval <= n_interval;
        r_repeat   <= n_repeat;
        r_cid      <= n_cid;
    end

endmodule

`default_nettype wire

// ===== rtl/core/one_shot_and_repeat_timer_table_top.sv =====
// Schedule: first-free search one slot a cycle, then one result.
// Cancel: no result; tick: slot walk through the slot RAM.
// One item at a time; the slot walk (one slot per cycle through a shared add/compare unit)
// sets the rate. Output stalls hold the walk only when a second timer fires.
// Synchronous active-low reset clears time, id counter, slot valid bits and handshakes;
// no clearing pass, ready the cycle after reset.
`default_nettype none

`include "one_shot_and_repeat_timer_table_top_assert.svh"

module one_shot_and_repeat_timer_table_top #(
    parameter int SLOTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [63:0] i_s_axis_tdata,  // interval_ticks[31:0], repeat_flag, cancel_id
    input  wire logic [1:0]  i_s_axis_tuser,  // opcode
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,  // timer_id_out[30:0], zero pad
    output logic [1:0]       o_m_axis_tuser,  // kind
    output logic             o_m_axis_tlast
);

    logic                      w_in_xfer;
    logic                      w_idle;
    logic                      w_out_free;
    ostt_pkg::t_push           w_push;

    logic                      r_out_vld;
    ostt_pkg::t_kind           r_out_kind;
    logic [ostt_pkg::ID_W-1:0] r_out_id;
    logic                      r_out_last;

    assign o_s_axis_tready = w_idle;
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_vld || i_m_axis_tready;

    ostt_seq #(.SLOTS(SLOTS)) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_xfer),
        .i_opcode   (i_s_axis_tuser),
        .i_interval (i_s_axis_tdata[31:0]),
        .i_repeat   (i_s_axis_tdata[32]),
        .i_cid      (i_s_axis_tdata[63:33]),
        .i_out_free (w_out_free),
        .o_idle     (w_idle),
        .o_push     (w_push)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= w_push.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_push.vld) begin
            r_out_kind <= w_push.kind;
            r_out_id   <= w_push.id;
            r_out_last <= w_push.last;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {1'b0, r_out_id};
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

    `OSTT_ASSERT_IMPL(a_push_room, w_push.vld, w_out_free, "result pushed into a busy output register")
    `OSTT_ASSERT_NEXT(a_busy_after_xfer, w_in_xfer && (i_s_axis_tuser != ostt_pkg::OP_NOP), !o_s_axis_tready, "ready high right after accepting work")
    `OSTT_ASSERT_IMPL(a_full_id_zero, o_m_axis_tvalid && (o_m_axis_tuser == ostt_pkg::KIND_FULL), o_m_axis_tdata == 32'd0, "table-full result carries nonzero id")

endmodule

`default_nettype wire

// ===== dv/one_shot_and_repeat_timer_table_top_tb.sv =====
`timescale 1ns / 100ps

module one_shot_and_repeat_timer_table_top_tb;

    localparam int TIMER_SLOTS = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 75;

    typedef struct packed {
        ostt_pkg::t_kind           kind;
        logic [ostt_pkg::ID_W-1:0] id;
        logic                      last;
    } t_id_result;

    // Tracks the timer table and queues the ids each transfer should produce.
    class timer_table_scoreboard;
        logic [ostt_pkg::NOW_W-1:0] now_tick;
        logic [ostt_pkg::ID_W-1:0]  next_id;
        bit                         live[TIMER_SLOTS];
        logic [ostt_pkg::NOW_W-1:0] target[TIMER_SLOTS];
        logic [ostt_pkg::PER_W-1:0] period[TIMER_SLOTS];
        bit                         reload[TIMER_SLOTS];
        logic [ostt_pkg::ID_W-1:0]  slot_id[TIMER_SLOTS];
        t_id_result                 expected_ids[$];
        int errors;
        int n_sched, n_full, n_cancel, n_tick, n_fired, n_checked;

        function new();
            now_tick = '0;
            next_id  = '0;
            foreach (live[i]) live[i] = 1'b0;
        endfunction

        function int live_count();
            int n;
            n = 0;
            foreach (live[i]) if (live[i]) n++;
            return n;
        endfunction

        function logic [ostt_pkg::ID_W-1:0] pick_live_id();
            int idx[$];
            foreach (live[i]) if (live[i]) idx.push_back(i);
            if (idx.size() == 0) return ostt_pkg::ID_W'($urandom);
            return slot_id[idx[$urandom_range(idx.size() - 1)]];
        endfunction

        function void note_item(logic [1:0] op, logic [ostt_pkg::PER_W-1:0] ivl, logic rf,
                                logic [ostt_pkg::ID_W-1:0] cid);
            int slot;
            t_id_result r;
            t_id_result fired[$];
            slot = -1;
            case (op)
                ostt_pkg::OP_SCHED: begin
                    n_sched++;
                    for (int i = 0; i < TIMER_SLOTS; i++) begin
                        if (!live[i] && slot < 0) slot = i;
                    end
                    r.last = 1'b1;
                    if (slot < 0) begin
                        n_full++;
                        r.kind = ostt_pkg::KIND_FULL;
                        r.id   = '0;
                    end else begin
                        next_id      = next_id + 1'b1;
                        live[slot]   = 1'b1;
                        target[slot] = now_tick + ostt_pkg::NOW_W'(ivl);
                        period[slot] = ivl;
                        reload[slot] = rf;
                        slot_id[slot] = next_id;
                        r.kind = ostt_pkg::KIND_ASSIGNED;
                        r.id   = next_id;
                    end
                    expected_ids.push_back(r);
                end
                ostt_pkg::OP_CANCEL: begin
                    n_cancel++;
                    for (int i = 0; i < TIMER_SLOTS; i++) begin
                        if (live[i] && slot_id[i] == cid) live[i] = 1'b0;
                    end
                end
                ostt_pkg::OP_TICK: begin
                    n_tick++;
                    now_tick = now_tick + 1'b1;
                    for (int i = 0; i < TIMER_SLOTS; i++) begin
                        if (live[i] && target[i] <= now_tick) begin
                            r.kind = ostt_pkg::KIND_FIRED;
                            r.id   = slot_id[i];
                            r.last = 1'b0;
                            fired.push_back(r);
                            if (reload[i]) target[i] = now_tick + ostt_pkg::NOW_W'(period[i]);
                            else live[i] = 1'b0;
                        end
                    end
                    if (fired.size() > 0) fired[fired.size() - 1].last = 1'b1;
                    n_fired += fired.size();
                    foreach (fired[i]) expected_ids.push_back(fired[i]);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [1:0] kind, logic [ostt_pkg::ID_W-1:0] id,
                                   logic last);
            t_id_result want;
            n_checked++;
            if (expected_ids.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result kind=%0d id=%0d last=%0b",
                             kind, id, last);
                return;
            end
            want = expected_ids.pop_front();
            if (want.kind !== kind || want.id !== id || want.last !== last) begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: result exp kind=%0d id=%0d last=%0b, ",
                              "got kind=%0d id=%0d last=%0b"},
                             want.kind, want.id, want.last, kind, id, last);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [63:0] s_tdata = '0;     // interval_ticks[31:0], repeat_flag, cancel_id
    logic [1:0]  s_tuser = '0;     // opcode
    logic        m_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;   // timer_id_out[30:0], zero pad
    logic [1:0]  o_m_axis_tuser;   // kind
    logic        o_m_axis_tlast;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycles = 0;

    timer_table_scoreboard sb = new();

    one_shot_and_repeat_timer_table_top #(
        .SLOTS(TIMER_SLOTS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL one_shot_and_repeat_timer_table_top");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // outputs only move at the rising edge; a transfer seen here completes at the next one
    always @(negedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_tready)
            sb.check_result(o_m_axis_tuser, o_m_axis_tdata[ostt_pkg::ID_W-1:0],
                            o_m_axis_tlast);
    end

    task automatic send_item(input logic [1:0] op, input logic [ostt_pkg::PER_W-1:0] ivl,
                             input logic rf, input logic [ostt_pkg::ID_W-1:0] cid);
        bit accepted;
        accepted = 1'b0;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cid, rf, ivl};
        s_tuser  <= op;
        while (!accepted) begin
            @(negedge i_clk);
            accepted = o_s_axis_tready;
        end
        sb.note_item(op, ivl, rf, cid);
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_ids.size() != 0);
    endtask

    task automatic send_random_item();
        int pick;
        logic [ostt_pkg::PER_W-1:0] ivl;
        pick = $urandom_range(99);
        if (sb.live_count() > 12 && pick < 40) pick = 90;
        if (pick < 38) begin
            case ($urandom_range(9))
                0:       ivl = $urandom;
                1, 2:    ivl = $urandom_range(40);
                default: ivl = $urandom_range(8);
            endcase
            send_item(ostt_pkg::OP_SCHED, ivl, 1'($urandom), ostt_pkg::ID_W'($urandom));
        end else if (pick < 82) begin
            send_item(ostt_pkg::OP_TICK, $urandom, 1'($urandom), ostt_pkg::ID_W'($urandom));
        end else if (pick < 97) begin
            if ($urandom_range(4) == 0)
                send_item(ostt_pkg::OP_CANCEL, $urandom, 1'($urandom),
                          ostt_pkg::ID_W'($urandom));
            else
                send_item(ostt_pkg::OP_CANCEL, $urandom, 1'($urandom), sb.pick_live_id());
        end else begin
            send_item(ostt_pkg::OP_NOP, $urandom, 1'($urandom), ostt_pkg::ID_W'($urandom));
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero interval, repeat at period zero, widest interval,
        // unknown and known cancel, unused opcode, table full, many fires on one tick
        send_item(ostt_pkg::OP_SCHED, 32'd0, 1'b0, '0);
        send_item(ostt_pkg::OP_TICK, '0, 1'b0, '0);
        send_item(ostt_pkg::OP_SCHED, 32'd0, 1'b1, '0);
        send_item(ostt_pkg::OP_TICK, '0, 1'b0, '0);
        send_item(ostt_pkg::OP_TICK, '0, 1'b0, '0);
        send_item(ostt_pkg::OP_SCHED, 32'hFFFF_FFFF, 1'b1, '0);
        send_item(ostt_pkg::OP_SCHED, 32'd3, 1'b0, '0);
        send_item(ostt_pkg::OP_CANCEL, '0, 1'b0, 31'h7FFF_FFFF);
        send_item(ostt_pkg::OP_CANCEL, '0, 1'b0, 31'd2);
        send_item(ostt_pkg::OP_NOP, 32'hFFFF_FFFF, 1'b1, 31'h7FFF_FFFF);
        for (int k = 0; k < 15; k++) send_item(ostt_pkg::OP_SCHED, 32'd2, k[0], '0);
        send_item(ostt_pkg::OP_SCHED, 32'd1, 1'b1, '0);
        repeat (3) send_item(ostt_pkg::OP_TICK, '0, 1'b0, '0);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            repeat (ITEMS_PER_PHASE) send_random_item();
            drain();
        end

        repeat (60) @(posedge i_clk);
        $display("covered %0d schedules (%0d with table full), %0d cancels, %0d ticks",
                 sb.n_sched, sb.n_full, sb.n_cancel, sb.n_tick);
        $display("%0d timers fired, %0d results checked across four stall mixes, %0d errors",
                 sb.n_fired, sb.n_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("PASS one_shot_and_repeat_timer_table_top");
        end else begin
            $display("FAIL one_shot_and_repeat_timer_table_top");
        end
        $finish;
    end

endmodule
